>>> sv/sfrq_pkg.sv
// shared types and constants of the shortest-first request queue
`timescale 1ns / 1ps

package sfrq_pkg;

    // fixed field widths
    localparam int HANDLE_W     = 16;
    localparam int SIZE_W       = 32;
    localparam int OCC_W        = 8;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 64;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        RD_HEAD,
        RD_TAIL,
        RD_PREV
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_MOVE
    } t_wr_sel;

    typedef enum logic [1:0] {
        RES_ENQ,
        RES_REJ,
        RES_DEQ
    } t_res_kind;

    typedef struct packed {
        logic      capture;
        logic      pos_load;
        logic      pos_dec;
        t_rd_sel   rd_sel;
        t_wr_sel   wr_sel;
        logic      head_inc;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic size_le;
        logic pos_one;
        logic out_valid;
    } t_dp_sts;

endpackage

>>> sv/sfrq_dp.sv
// datapath: entry memory, pointers, insertion walk registers and result register
`timescale 1ns / 1ps

module sfrq_dp import sfrq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [HANDLE_W-1:0]    i_handle,
    input  logic [SIZE_W-1:0]      i_size,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int OW = (CW > OCC_W) ? CW : OCC_W;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [HANDLE_W-1:0] r_handle_mem [QUEUE_DEPTH];
    logic [SIZE_W-1:0]   r_size_mem   [QUEUE_DEPTH];

    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_count, n_count;
    logic [AW-1:0]          r_pos;
    logic [HANDLE_W-1:0]    r_new_handle;
    logic [SIZE_W-1:0]      r_new_size;
    logic [HANDLE_W-1:0]    r_rd_handle;
    logic [SIZE_W-1:0]      r_rd_size;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [CW-1:0]       count_m1;
    logic [AW-1:0]       pos_m2;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_en;
    logic [HANDLE_W-1:0] wr_handle;
    logic [SIZE_W-1:0]   wr_size;
    logic [OW-1:0]       occ_ext;

    // physical slot of a logical offset from the head
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[AW-1:0];
    endfunction

    assign count_m1 = r_count - CW'(1);
    assign pos_m2   = r_pos - AW'(2);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_HEAD: rd_addr = r_head;
            RD_TAIL: rd_addr = f_slot(r_head, count_m1[AW-1:0]);
            RD_PREV: rd_addr = f_slot(r_head, pos_m2);
            default: rd_addr = r_head;
        endcase
    end

    assign wr_addr = f_slot(r_head, r_pos);

    always_comb begin
        wr_en     = 1'b0;
        wr_handle = r_new_handle;
        wr_size   = r_new_size;
        case (i_cmd.wr_sel)
            WR_NEW: begin
                wr_en = 1'b1;
            end
            WR_MOVE: begin
                wr_en     = 1'b1;
                wr_handle = r_rd_handle;
                wr_size   = r_rd_size;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_handle_mem[wr_addr] <= wr_handle;
            r_size_mem[wr_addr]   <= wr_size;
        end
        r_rd_handle <= r_handle_mem[rd_addr];
        r_rd_size   <= r_size_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = count_m1;
        end
    end

    // occupancy is reported modulo 256
    assign occ_ext = OW'(n_count);

    always_comb begin
        n_out_data        = '0;
        n_out_data[57:50] = occ_ext[OCC_W-1:0];
        case (i_cmd.res_kind)
            RES_DEQ: begin
                n_out_data[0]     = 1'b1;
                n_out_data[16:1]  = r_rd_handle;
                n_out_data[48:17] = r_rd_size;
            end
            RES_REJ: n_out_data[49] = 1'b1;
            default: n_out_data[49] = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.head_inc) begin
                r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_new_handle <= i_handle;
            r_new_size   <= i_size;
        end
        if (i_cmd.pos_load) begin
            r_pos <= r_count[AW-1:0];
        end else if (i_cmd.pos_dec) begin
            r_pos <= r_pos - AW'(1);
        end
        if (i_cmd.res_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == DEPTH_C);
    assign o_sts.size_le   = (r_rd_size <= r_new_size);
    assign o_sts.pos_one   = (r_pos == AW'(1));
    assign o_sts.out_valid = r_out_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> sv/sfrq_ctrl.sv
// controller: mode register and the state machine that sequences each request
`timescale 1ns / 1ps

module sfrq_ctrl import sfrq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  logic    i_op,
    input  logic    i_m_tready,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  logic    i_cfg_data,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_PLACE = 4'b0100,
        ST_DEQ   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_shortest_first;
    logic   s_fire;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE) && (!i_sts.out_valid || i_m_tready);
    assign s_fire      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_shortest_first <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_shortest_first <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_HEAD;
        o_cmd.wr_sel   = WR_NONE;
        o_cmd.res_kind = RES_ENQ;
        unique case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    o_cmd.capture  = 1'b1;
                    o_cmd.pos_load = 1'b1;
                    if (i_op == OP_DEQ) begin
                        if (i_sts.empty) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_kind = RES_REJ;
                        end else begin
                            o_cmd.rd_sel = RD_HEAD;
                            n_state      = ST_DEQ;
                        end
                    end else if (i_sts.full) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = RES_REJ;
                    end else if (!r_shortest_first || i_sts.empty) begin
                        n_state = ST_PLACE;
                    end else begin
                        o_cmd.rd_sel = RD_TAIL;
                        n_state      = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (i_sts.size_le) begin
                    o_cmd.wr_sel   = WR_NEW;
                    o_cmd.cnt_inc  = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    // shift the larger entry back one slot and look one further
                    o_cmd.wr_sel  = WR_MOVE;
                    o_cmd.pos_dec = 1'b1;
                    o_cmd.rd_sel  = RD_PREV;
                    if (i_sts.pos_one) begin
                        n_state = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                o_cmd.wr_sel   = WR_NEW;
                o_cmd.cnt_inc  = 1'b1;
                o_cmd.res_load = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_DEQ: begin
                o_cmd.head_inc = 1'b1;
                o_cmd.cnt_dec  = 1'b1;
                o_cmd.res_load = 1'b1;
                o_cmd.res_kind = RES_DEQ;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> sv/shortest_first_request_queue.sv
// top level of the shortest-first request queue
`timescale 1ns / 1ps

// pending request queue of QUEUE_DEPTH entries, each a 16-bit handle and a 32-bit
// job size. every input transfer is one request (enqueue or dequeue) and yields
// exactly one result transfer. in first-come mode an enqueue goes to the tail; in
// shortest-first mode it is inserted behind every entry of smaller or equal size,
// so equal sizes keep arrival order. a dequeue returns the head entry. enqueue
// into a full queue and dequeue from an empty queue come back with rejected set
// and the served fields zero. switching mode never reorders pending entries.
// a reject is loaded into the result register straight from the idle state; a
// dequeue first reads the head entry; an enqueue writes the new entry, in
// shortest-first mode after moving each larger entry back one slot, walking
// from the tail. the insertion walk moves one entry per cycle through the
// entry memory (one write and one registered read per cycle). one request is
// in progress at a time; the result sits in an output register, so a new
// request is taken in the same cycle that the previous result is transferred.
// the entry memory needs no clearing after reset: only occupied slots are read.
// the mode register is written through the cfg channel, always ready, and is
// meant to change only while no request is in progress.

module shortest_first_request_queue import sfrq_pkg::*; #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation[0], request_handle[16:1], job_size[48:17], zero fill [55:49]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // served_valid[0], served_handle[16:1], served_size[48:17], rejected[49],
    // occupancy[57:50], zero fill [63:58]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // mode register write: shortest_first
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing of enqueue, insertion walk and dequeue
    sfrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_op        (s_axis_tdata[0]),
        .i_m_tready  (m_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // entry storage, pointers and result register
    sfrq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .i_handle   (s_axis_tdata[16:1]),
        .i_size     (s_axis_tdata[48:17]),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule
